FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl of the bytecode execute block
// all checks are clocked on clock and held off while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bcx_pkg.sv
// constants of the bytecode execute block: opcodes, operand modes, register
// indexes, fault codes and csr indexes; no dependencies
`timescale 1ns / 1ps

package bcx_pkg;

   localparam logic [4:0] OP_NOP   = 5'd0;
   localparam logic [4:0] OP_MOV   = 5'd1;
   localparam logic [4:0] OP_ADD   = 5'd2;
   localparam logic [4:0] OP_SUB   = 5'd3;
   localparam logic [4:0] OP_JMP   = 5'd4;
   localparam logic [4:0] OP_PUSH  = 5'd5;
   localparam logic [4:0] OP_POP   = 5'd6;
   localparam logic [4:0] OP_CALL  = 5'd7;
   localparam logic [4:0] OP_RET   = 5'd8;
   localparam logic [4:0] OP_ENTER = 5'd9;
   localparam logic [4:0] OP_LEAVE = 5'd10;
   localparam logic [4:0] OP_CMP   = 5'd11;
   localparam logic [4:0] OP_JE    = 5'd12;
   localparam logic [4:0] OP_JNE   = 5'd13;
   localparam logic [4:0] OP_JG    = 5'd14;
   localparam logic [4:0] OP_JL    = 5'd15;
   localparam logic [4:0] OP_JGE   = 5'd16;
   localparam logic [4:0] OP_JLE   = 5'd17;
   localparam logic [4:0] OP_JZ    = 5'd18;
   localparam logic [4:0] OP_JNZ   = 5'd19;
   localparam logic [4:0] OP_MUL   = 5'd20;
   localparam logic [4:0] OP_DIV   = 5'd21;
   localparam logic [4:0] OP_MOD   = 5'd22;
   localparam logic [4:0] OP_SHR   = 5'd23;
   localparam logic [4:0] OP_SHL   = 5'd24;
   localparam logic [4:0] OP_AND   = 5'd25;
   localparam logic [4:0] OP_OR    = 5'd26;
   localparam logic [4:0] OP_XOR   = 5'd27;
   localparam logic [4:0] OP_HOST  = 5'd28;

   localparam logic [3:0] MD_NONE  = 4'd0;
   localparam logic [3:0] MD_REG   = 4'd1;
   localparam logic [3:0] MD_REGB  = 4'd2;
   localparam logic [3:0] MD_IMM   = 4'd3;
   localparam logic [3:0] MD_IMMB  = 4'd4;
   localparam logic [3:0] MD_ADDR  = 4'd5;
   localparam logic [3:0] MD_IND   = 4'd6;
   localparam logic [3:0] MD_LABEL = 4'd7;
   localparam logic [3:0] MD_ARG   = 4'd8;
   localparam logic [3:0] MD_INDB  = 4'd9;

   localparam logic [3:0] R_DP = 4'd11;
   localparam logic [3:0] R_BP = 4'd12;
   localparam logic [3:0] R_SP = 4'd13;
   localparam logic [3:0] R_PC = 4'd14;
   localparam logic [3:0] R_CF = 4'd15;

   localparam logic [31:0] ARG_BIAS = 32'd12;

   localparam logic [1:0] FLT_NONE    = 2'd0;
   localparam logic [1:0] FLT_DIV0    = 2'd1;
   localparam logic [1:0] FLT_ILLEGAL = 2'd2;

   localparam logic [0:0]  CSR_CODE_START = 1'b0;
   localparam logic [31:0] CODE_START_RESET = 32'd1;

endpackage

FILE: rtl/bcx_if.sv
// request and response channel interfaces of the bytecode execute block
// valid/ready handshake with the instruction or result word; no dependencies
`timescale 1ns / 1ps

interface bcx_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  opcode;
   logic [3:0]  mode_first;
   logic [3:0]  mode_second;
   logic [31:0] field_first;
   logic [31:0] field_second;

   modport source (output valid, opcode, mode_first, mode_second, field_first,
                   field_second, input ready);
   modport sink (input valid, opcode, mode_first, mode_second, field_first,
                 field_second, output ready);
endinterface

interface bcx_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_pc;
   logic [31:0] result_value;
   logic        halted;
   logic        host_call;
   logic [31:0] call_target;
   logic [1:0]  fault;

   modport source (output valid, next_pc, result_value, halted, host_call,
                   call_target, fault, input ready);
   modport sink (input valid, next_pc, result_value, halted, host_call,
                 call_target, fault, output ready);
endinterface

FILE: rtl/bytecode_cpu_execute.sv
// bytecode execute block: one pre-fetched stack machine instruction per word.
// operands, memory reads, execute, write-back and stores run in turn; a halted pc (zero)
// skips straight to the response. one word in flight; the next can be taken in the cycle
// its result is presented. reset: synchronous; pc = code_start, sp = top - 8, then a
// clearing pass zeroes all DATA_BYTES + 4*STACK_WORDS bytes of the ram.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bytecode_cpu_execute #(
   parameter int DATA_BYTES  = 16384,
   parameter int STACK_WORDS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   bcx_req_if.sink     req_chan,
   bcx_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import bcx_pkg::*;

   localparam int          MEM_BYTES = DATA_BYTES + 4 * STACK_WORDS;
   localparam int          AW        = $clog2(MEM_BYTES);
   localparam logic [31:0] MEM_TOP   = 32'(MEM_BYTES);
   localparam logic [31:0] WORD_MAX  = MEM_TOP - 32'd4;
   localparam logic [31:0] SP_RESET  = MEM_TOP - 32'd8;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_OPND   = 4'd2;
   localparam logic [3:0] S_OPFIN  = 4'd3;
   localparam logic [3:0] S_EXEC   = 4'd4;
   localparam logic [3:0] S_MRDA   = 4'd5;
   localparam logic [3:0] S_MRDD   = 4'd6;
   localparam logic [3:0] S_POPFIN = 4'd7;
   localparam logic [3:0] S_LEAVE1 = 4'd8;
   localparam logic [3:0] S_LEAVE2 = 4'd9;
   localparam logic [3:0] S_DIV    = 4'd10;
   localparam logic [3:0] S_DIVFIN = 4'd11;
   localparam logic [3:0] S_WB     = 4'd12;
   localparam logic [3:0] S_MWR    = 4'd13;
   localparam logic [3:0] S_FIN    = 4'd14;

   typedef struct packed {
      logic [4:0]  op;
      logic [3:0]  m1;
      logic [3:0]  m2;
      logic [31:0] f1;
      logic [31:0] f2;
      logic [31:0] pc;
      logic [31:0] npc;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] r;
      logic [31:0] dst;
      logic [31:0] sp;
      logic [31:0] bp;
      logic [31:0] cf;
      logic        wb;
      logic        host;
      logic [1:0]  fault;
      logic        opnd;
      logic [31:0] maddr;
      logic        mword;
      logic [1:0]  cnt;
      logic [31:0] mdata;
      logic [3:0]  ret;
      logic [31:0] wad;
      logic [31:0] wval;
      logic        wword;
      logic [31:0] dquo;
      logic [31:0] drem;
      logic [4:0]  dcnt;
      logic        dna;
      logic        dnb;
   } work_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [31:0] result_value;
      logic        halted;
      logic        host_call;
      logic [31:0] call_target;
      logic [1:0]  fault;
   } rsp_type;

   logic [3:0]    state_ff, state_in;
   work_type      wk_ff, wk_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rf_ff [16];
   logic [31:0]   rf_in [16];
   logic [31:0]   code_start_ff, code_start_in;
   logic [AW-1:0] clr_ff, clr_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;

   logic          req_acc, csr_wr, commit;

   // operand unit
   logic [3:0]  o_mode;
   logic [31:0] o_fld, o_rsel, o_val, o_len, o_ad;
   logic        o_read, o_word, o_bad;

   // divider step
   logic [32:0] d_sh, d_diff;

   bcx_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_acc = req_chan.valid && req_chan.ready;
   assign csr_wr  = psel && penable && pwrite && pready && (paddr[2:2] == CSR_CODE_START);
   assign pready  = 1'b1;
   assign prdata  = (paddr[2:2] == CSR_CODE_START) ? code_start_ff : 32'd0;
   assign commit  = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_chan.ready)
                    && (wk_ff.fault == FLT_NONE);

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.next_pc   = rsp_ff.next_pc;
   assign rsp_chan.result_value = rsp_ff.result_value;
   assign rsp_chan.halted    = rsp_ff.halted;
   assign rsp_chan.host_call = rsp_ff.host_call;
   assign rsp_chan.call_target = rsp_ff.call_target;
   assign rsp_chan.fault     = rsp_ff.fault;

   always_comb begin
      o_mode = wk_ff.opnd ? wk_ff.m2 : wk_ff.m1;
      o_fld  = wk_ff.opnd ? wk_ff.f2 : wk_ff.f1;
      o_rsel = rf_ff[o_fld[3:0]];
      o_val  = 32'd0;
      o_len  = 32'd1;
      o_ad   = o_rsel;
      o_read = 1'b0;
      o_word = 1'b1;
      o_bad  = 1'b0;
      unique case (o_mode)
         MD_NONE:  o_len = 32'd0;
         MD_REG:   o_val = o_rsel;
         MD_REGB:  o_val = {24'd0, o_rsel[7:0]};
         MD_IMM: begin
            o_val = o_fld;
            o_len = 32'd4;
         end
         MD_IMMB:  o_val = {24'd0, o_fld[7:0]};
         MD_IND: begin
            o_read = 1'b1;
            o_bad  = (o_ad > WORD_MAX);
         end
         MD_LABEL: begin
            o_val = wk_ff.pc + o_fld;
            o_len = 32'd4;
         end
         MD_ARG: begin
            o_ad   = rf_ff[R_BP] - {o_fld[29:0], 2'b00} + ARG_BIAS;
            o_read = 1'b1;
            o_bad  = (o_ad > WORD_MAX);
         end
         MD_INDB: begin
            o_read = 1'b1;
            o_word = 1'b0;
            o_bad  = (o_ad >= MEM_TOP);
         end
         default: begin
            o_len = 32'd0;
            o_bad = 1'b1;
         end
      endcase
   end

   assign d_sh   = {wk_ff.drem, wk_ff.dquo[31]};
   assign d_diff = d_sh - {1'b0, wk_ff.b};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      wk_in        = wk_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      clr_in       = clr_ff;
      ram_we       = 1'b0;
      ram_waddr    = wk_ff.wad[AW-1:0] + AW'(wk_ff.cnt);
      ram_wdata    = wk_ff.wval[{wk_ff.cnt, 3'b000} +: 8];
      ram_raddr    = wk_ff.maddr[AW-1:0] + AW'(wk_ff.cnt);

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = 8'd0;
            if (clr_ff == AW'(MEM_BYTES - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               wk_in.op    = req_chan.opcode;
               wk_in.m1    = req_chan.mode_first;
               wk_in.m2    = req_chan.mode_second;
               wk_in.f1    = req_chan.field_first;
               wk_in.f2    = req_chan.field_second;
               wk_in.pc    = rf_ff[R_PC];
               wk_in.npc   = rf_ff[R_PC] + 32'd2;
               wk_in.sp    = rf_ff[R_SP];
               wk_in.bp    = rf_ff[R_BP];
               wk_in.cf    = rf_ff[R_CF];
               wk_in.a     = 32'd0;
               wk_in.b     = 32'd0;
               wk_in.r     = 32'd0;
               wk_in.wb    = 1'b0;
               wk_in.host  = 1'b0;
               wk_in.fault = FLT_NONE;
               wk_in.opnd  = 1'b0;
               if (rf_ff[R_PC] == 32'd0) begin
                  // already halted: report pc zero and change nothing
                  wk_in.npc = 32'd0;
                  state_in  = S_FIN;
               end else begin
                  state_in = S_OPND;
               end
            end
         end
         S_OPND: begin
            wk_in.npc = wk_ff.npc + o_len;
            if (!wk_ff.opnd) begin
               wk_in.dst = o_rsel;
            end
            if (o_bad) begin
               wk_in.fault = FLT_ILLEGAL;
               state_in    = S_FIN;
            end else if (o_read) begin
               wk_in.maddr = o_ad;
               wk_in.mword = o_word;
               wk_in.cnt   = 2'd0;
               wk_in.mdata = 32'd0;
               wk_in.ret   = S_OPFIN;
               state_in    = S_MRDA;
            end else begin
               if (wk_ff.opnd) begin
                  wk_in.b  = o_val;
                  state_in = S_EXEC;
               end else begin
                  wk_in.a    = o_val;
                  wk_in.opnd = 1'b1;
               end
            end
         end
         S_OPFIN: begin
            if (wk_ff.opnd) begin
               wk_in.b  = wk_ff.mdata;
               state_in = S_EXEC;
            end else begin
               wk_in.a    = wk_ff.mdata;
               wk_in.opnd = 1'b1;
               state_in   = S_OPND;
            end
         end
         S_MRDA: state_in = S_MRDD;
         S_MRDD: begin
            wk_in.mdata[{wk_ff.cnt, 3'b000} +: 8] = ram_rdata;
            if (!wk_ff.mword || wk_ff.cnt == 2'd3) begin
               state_in = wk_ff.ret;
            end else begin
               wk_in.cnt = wk_ff.cnt + 2'd1;
               state_in  = S_MRDA;
            end
         end
         S_EXEC: begin
            state_in = S_WB;
            case (wk_ff.op) inside
               OP_MOV: begin
                  wk_in.r  = wk_ff.b;
                  wk_in.wb = 1'b1;
               end
               OP_ADD: begin
                  wk_in.r  = wk_ff.a + wk_ff.b;
                  wk_in.wb = 1'b1;
               end
               OP_SUB: begin
                  wk_in.r  = wk_ff.a - wk_ff.b;
                  wk_in.wb = 1'b1;
               end
               OP_JMP: wk_in.npc = wk_ff.a;
               OP_PUSH, OP_CALL, OP_ENTER: begin
                  if (wk_ff.sp > WORD_MAX) begin
                     wk_in.fault = FLT_ILLEGAL;
                     state_in    = S_FIN;
                  end else begin
                     wk_in.wad   = wk_ff.sp;
                     wk_in.wword = 1'b1;
                     wk_in.cnt   = 2'd0;
                     wk_in.wval  = (wk_ff.op == OP_PUSH) ? wk_ff.a :
                                   (wk_ff.op == OP_CALL) ? wk_ff.npc : wk_ff.bp;
                     wk_in.sp    = wk_ff.sp - 32'd4;
                     if (wk_ff.op == OP_CALL) begin
                        wk_in.npc = wk_ff.a;
                     end
                     if (wk_ff.op == OP_ENTER) begin
                        wk_in.bp = wk_ff.sp - 32'd4;
                     end
                     state_in = S_MWR;
                  end
               end
               OP_POP, OP_RET: begin
                  wk_in.sp = wk_ff.sp + 32'd4;
                  if (wk_ff.sp + 32'd4 > WORD_MAX) begin
                     wk_in.fault = FLT_ILLEGAL;
                     state_in    = S_FIN;
                  end else begin
                     wk_in.maddr = wk_ff.sp + 32'd4;
                     wk_in.mword = 1'b1;
                     wk_in.cnt   = 2'd0;
                     wk_in.mdata = 32'd0;
                     wk_in.ret   = S_POPFIN;
                     state_in    = S_MRDA;
                  end
               end
               OP_LEAVE: begin
                  wk_in.sp = wk_ff.bp + 32'd4;
                  if (wk_ff.bp + 32'd4 > WORD_MAX) begin
                     wk_in.fault = FLT_ILLEGAL;
                     state_in    = S_FIN;
                  end else begin
                     wk_in.maddr = wk_ff.bp + 32'd4;
                     wk_in.mword = 1'b1;
                     wk_in.cnt   = 2'd0;
                     wk_in.mdata = 32'd0;
                     wk_in.ret   = S_LEAVE1;
                     state_in    = S_MRDA;
                  end
               end
               OP_CMP: begin
                  wk_in.r  = wk_ff.a - wk_ff.b;
                  wk_in.cf = wk_ff.a - wk_ff.b;
               end
               OP_JE: if (wk_ff.cf == 32'd0) wk_in.npc = wk_ff.a;
               OP_JNE: if (wk_ff.cf != 32'd0) wk_in.npc = wk_ff.a;
               OP_JG: if (wk_ff.cf != 32'd0 && !wk_ff.cf[31]) wk_in.npc = wk_ff.a;
               OP_JL: if (wk_ff.cf[31]) wk_in.npc = wk_ff.a;
               OP_JGE: if (!wk_ff.cf[31]) wk_in.npc = wk_ff.a;
               OP_JLE: if (wk_ff.cf == 32'd0 || wk_ff.cf[31]) wk_in.npc = wk_ff.a;
               // both jump only when a is zero, and then to address zero
               OP_JZ, OP_JNZ: if (wk_ff.a == 32'd0) wk_in.npc = 32'd0;
               OP_MUL: begin
                  wk_in.r  = wk_ff.a * wk_ff.b;
                  wk_in.wb = 1'b1;
               end
               OP_DIV, OP_MOD: begin
                  if (wk_ff.b == 32'd0) begin
                     wk_in.fault = FLT_DIV0;
                     state_in    = S_FIN;
                  end else begin
                     // divide magnitudes, fix signs at the end
                     wk_in.dna  = wk_ff.a[31];
                     wk_in.dnb  = wk_ff.b[31];
                     wk_in.dquo = wk_ff.a[31] ? 32'd0 - wk_ff.a : wk_ff.a;
                     wk_in.b    = wk_ff.b[31] ? 32'd0 - wk_ff.b : wk_ff.b;
                     wk_in.drem = 32'd0;
                     wk_in.dcnt = 5'd31;
                     state_in   = S_DIV;
                  end
               end
               OP_SHR: begin
                  wk_in.r  = wk_ff.a >> wk_ff.b[4:0];
                  wk_in.wb = 1'b1;
               end
               OP_SHL: begin
                  wk_in.r  = wk_ff.a << wk_ff.b[4:0];
                  wk_in.wb = 1'b1;
               end
               OP_AND: begin
                  wk_in.r  = wk_ff.a & wk_ff.b;
                  wk_in.wb = 1'b1;
               end
               OP_OR: begin
                  wk_in.r  = wk_ff.a | wk_ff.b;
                  wk_in.wb = 1'b1;
               end
               OP_XOR: begin
                  wk_in.r  = wk_ff.a ^ wk_ff.b;
                  wk_in.wb = 1'b1;
               end
               OP_HOST: wk_in.host = 1'b1;
               default: ;
            endcase
         end
         S_POPFIN: begin
            if (wk_ff.op == OP_POP) begin
               wk_in.r  = wk_ff.mdata;
               wk_in.wb = 1'b1;
               state_in = S_WB;
            end else begin
               wk_in.npc = wk_ff.mdata;
               wk_in.sp  = wk_ff.sp + wk_ff.a;
               state_in  = S_FIN;
            end
         end
         S_LEAVE1: begin
            wk_in.bp = wk_ff.mdata;
            wk_in.sp = wk_ff.sp + 32'd4;
            if (wk_ff.sp + 32'd4 > WORD_MAX) begin
               wk_in.fault = FLT_ILLEGAL;
               state_in    = S_FIN;
            end else begin
               wk_in.maddr = wk_ff.sp + 32'd4;
               wk_in.cnt   = 2'd0;
               wk_in.mdata = 32'd0;
               wk_in.ret   = S_LEAVE2;
               state_in    = S_MRDA;
            end
         end
         S_LEAVE2: begin
            wk_in.npc = wk_ff.mdata;
            wk_in.sp  = wk_ff.sp + wk_ff.a;
            state_in  = S_FIN;
         end
         S_DIV: begin
            // restoring divide, one quotient bit a cycle
            if (!d_diff[32]) begin
               wk_in.drem = d_diff[31:0];
            end else begin
               wk_in.drem = d_sh[31:0];
            end
            wk_in.dquo = {wk_ff.dquo[30:0], !d_diff[32]};
            wk_in.dcnt = wk_ff.dcnt - 5'd1;
            if (wk_ff.dcnt == 5'd0) begin
               state_in = S_DIVFIN;
            end
         end
         S_DIVFIN: begin
            if (wk_ff.op == OP_DIV) begin
               wk_in.r = (wk_ff.dna != wk_ff.dnb) ? 32'd0 - wk_ff.dquo : wk_ff.dquo;
            end else begin
               wk_in.r = wk_ff.dna ? 32'd0 - wk_ff.drem : wk_ff.drem;
            end
            wk_in.wb = 1'b1;
            state_in = S_WB;
         end
         S_WB: begin
            state_in = S_FIN;
            if (wk_ff.wb && wk_ff.m1 == MD_IND) begin
               if (wk_ff.dst > WORD_MAX) begin
                  wk_in.fault = FLT_ILLEGAL;
               end else begin
                  wk_in.wad   = wk_ff.dst;
                  wk_in.wval  = wk_ff.r;
                  wk_in.wword = 1'b1;
                  wk_in.cnt   = 2'd0;
                  state_in    = S_MWR;
               end
            end else if (wk_ff.wb && wk_ff.m1 == MD_INDB) begin
               if (wk_ff.dst >= MEM_TOP) begin
                  wk_in.fault = FLT_ILLEGAL;
               end else begin
                  wk_in.wad   = wk_ff.dst;
                  wk_in.wval  = wk_ff.r;
                  wk_in.wword = 1'b0;
                  wk_in.cnt   = 2'd0;
                  state_in    = S_MWR;
               end
            end
         end
         S_MWR: begin
            ram_we = 1'b1;
            if (!wk_ff.wword || wk_ff.cnt == 2'd3) begin
               state_in = S_FIN;
            end else begin
               wk_in.cnt = wk_ff.cnt + 2'd1;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (wk_ff.fault != FLT_NONE) begin
                  rsp_in.next_pc      = wk_ff.pc;
                  rsp_in.result_value = 32'd0;
                  rsp_in.halted       = (wk_ff.pc == 32'd0);
                  rsp_in.host_call    = 1'b0;
                  rsp_in.call_target  = 32'd0;
                  rsp_in.fault        = wk_ff.fault;
               end else begin
                  rsp_in.next_pc      = wk_ff.npc;
                  rsp_in.result_value = wk_ff.r;
                  rsp_in.halted       = (wk_ff.npc == 32'd0);
                  rsp_in.host_call    = wk_ff.host;
                  rsp_in.call_target  = wk_ff.host ? wk_ff.a : 32'd0;
                  rsp_in.fault        = FLT_NONE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // register file commit: staged sp/bp/cf, then register write-back, then pc; a csr write sets code_start and pc
   always_comb begin
      rf_in         = rf_ff;
      code_start_in = code_start_ff;
      if (commit) begin
         rf_in[R_SP] = wk_ff.sp;
         rf_in[R_BP] = wk_ff.bp;
         rf_in[R_CF] = wk_ff.cf;
         if (wk_ff.wb && wk_ff.m1 == MD_REG) begin
            rf_in[wk_ff.f1[3:0]] = wk_ff.r;
         end else if (wk_ff.wb && wk_ff.m1 == MD_REGB) begin
            rf_in[wk_ff.f1[3:0]] = {24'd0, wk_ff.r[7:0]};
         end
         rf_in[R_PC] = wk_ff.npc;
      end
      if (csr_wr) begin
         code_start_in = pwdata;
         rf_in[R_PC]   = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      wk_ff  <= wk_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         code_start_ff <= CODE_START_RESET;
         for (int i = 0; i < 16; i++) begin
            rf_ff[i] <= (i == int'(R_PC)) ? CODE_START_RESET :
                        (i == int'(R_SP)) ? SP_RESET : 32'd0;
         end
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
         code_start_ff <= code_start_in;
         rf_ff         <= rf_in;
      end
   end

   `ASSERT_IMPL(a_fault_quiet, rsp_chan.valid && rsp_chan.fault != FLT_NONE,
      !rsp_chan.host_call && rsp_chan.result_value == 32'd0,
      "faulting word reports a result or host call")
   `ASSERT_IMPL(a_halt_flag, rsp_chan.valid,
      rsp_chan.halted == (rsp_chan.next_pc == 32'd0), "halted disagrees with next pc")
   `ASSERT_IMPL(a_ram_write_state, ram_we, state_ff == S_CLEAR || state_ff == S_MWR,
      "ram written outside clear or store")
   `ASSERT_NEXT(a_busy_after_accept, req_acc, state_ff != S_IDLE && state_ff != S_CLEAR,
      "sequencer idle right after accept")

endmodule

FILE: rtl/bcx_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bcx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
